// ===== rtl/core/mcot_pkg.sv =====
// Shared types and constants for the multi-channel one-shot timer core.
// Has no dependencies; every other file in rtl/core imports it.
package mcot_pkg;

    // Number of timer channels and the width of each down counter.
    localparam int CHANNELS    = 8;
    localparam int COUNT_WIDTH = 32;

    // Width of a channel index inside the core.
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Depth of the command queue between front and back.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Codes of the kind field of an input item.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    // Input item as it crosses the input port.
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  channel;
        logic        deferred;
        logic [31:0] ticks;
    } t_in_item;

    // Result item as it crosses the output port.
    typedef struct packed {
        logic [2:0] expired_channel;
        logic       expired_deferred;
        logic       last;
    } t_out_item;

    // Operations that the front hands to the back.
    typedef enum logic [1:0] {
        OP_TICK,
        OP_START,
        OP_STOP
    } t_op;

    // One classified command held in the queue.
    typedef struct packed {
        t_op                    op;
        logic [CH_W-1:0]        chan;
        logic                   deferred;
        logic [COUNT_WIDTH-1:0] count;
    } t_cmd;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // States of the back-end sequencer.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FLUSH
    } t_back_state;

endpackage

// ===== rtl/core/mcot_front.sv =====
// Front end: accepts input items and turns them into queue commands.
// Depends on mcot_pkg for the item and command types.
module mcot_front
    import mcot_pkg::*;
(
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic chan_ok;
    logic keep;

    // Items that do nothing (unknown kind, channel out of range) are
    // accepted and dropped here, so they never occupy the queue.
    always_comb begin
        chan_ok          = (32'(i_in_item.channel) < 32'(CHANNELS));
        keep             = 1'b0;
        o_cmd.op         = OP_TICK;
        o_cmd.chan       = CH_W'(i_in_item.channel);
        o_cmd.deferred   = i_in_item.deferred;
        o_cmd.count      = i_in_item.ticks[COUNT_WIDTH-1:0];
        case (i_in_item.kind)
            KIND_TICK: begin
                keep     = 1'b1;
                o_cmd.op = OP_TICK;
            end
            KIND_START: begin
                keep     = chan_ok;
                o_cmd.op = OP_START;
            end
            KIND_STOP: begin
                keep     = chan_ok;
                o_cmd.op = OP_STOP;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full && keep && i_rst_n;

endmodule

// ===== rtl/core/mcot_queue.sv =====
// Short command queue that decouples the front end from the back end.
// Depends on mcot_pkg for the command type and queue depth.
module mcot_queue
    import mcot_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_cmd          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/mcot_back.sv =====
// Back end: executes start, stop and tick commands against the timer bank
// and drives the result register. Depends on mcot_pkg.
module mcot_back
    import mcot_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_status i_q_status,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_back_state            r_state;
    t_back_state            n_state;
    logic [CH_W-1:0]        r_idx;
    logic [CH_W-1:0]        n_idx;
    logic [CHANNELS-1:0]    r_active;
    logic [CHANNELS-1:0]    n_active;
    logic [CHANNELS-1:0]    r_mode;
    logic [CHANNELS-1:0]    n_mode;
    logic                   r_pend_valid;
    logic                   n_pend_valid;
    logic [2:0]             r_pend_ch;
    logic [2:0]             n_pend_ch;
    logic                   r_pend_mode;
    logic                   n_pend_mode;
    logic                   r_out_valid;
    logic                   n_out_valid;
    t_out_item              r_out_item;
    t_out_item              n_out_item;
    logic [COUNT_WIDTH-1:0] r_remaining [CHANNELS];

    logic                   wr_en;
    logic [CH_W-1:0]        wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic [COUNT_WIDTH-1:0] dec;
    logic                   hit;
    logic                   need_push;
    logic                   out_free;

    always_comb begin
        dec          = r_remaining[r_idx] - 1'b1;
        hit          = r_active[r_idx] && (dec == '0);
        need_push    = hit && r_pend_valid;
        out_free     = !r_out_valid || !i_out_stall;

        n_state      = r_state;
        n_idx        = r_idx;
        n_active     = r_active;
        n_mode       = r_mode;
        n_pend_valid = r_pend_valid;
        n_pend_ch    = r_pend_ch;
        n_pend_mode  = r_pend_mode;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_item   = r_out_item;
        o_pop        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = dec;

        case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_START: begin
                            wr_en                = 1'b1;
                            wr_addr              = i_cmd.chan;
                            wr_data              = i_cmd.count;
                            n_active[i_cmd.chan] = 1'b1;
                            n_mode[i_cmd.chan]   = i_cmd.deferred;
                        end
                        OP_STOP: begin
                            n_active[i_cmd.chan] = 1'b0;
                        end
                        OP_TICK: begin
                            n_state = ST_SWEEP;
                            n_idx   = '0;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                // An expiry is held back until the next one is found, so that the last
                // report of the tick can be flagged once the sweep is complete.
                if (!need_push || out_free) begin
                    if (r_active[r_idx]) begin
                        wr_en = 1'b1;
                    end
                    if (hit) begin
                        n_active[r_idx] = 1'b0;
                        n_pend_valid    = 1'b1;
                        n_pend_ch       = 3'(r_idx);
                        n_pend_mode     = r_mode[r_idx];
                    end
                    if (need_push) begin
                        n_out_valid                 = 1'b1;
                        n_out_item.expired_channel  = r_pend_ch;
                        n_out_item.expired_deferred = r_pend_mode;
                        n_out_item.last             = 1'b0;
                    end
                    if (r_idx == CH_W'(CHANNELS - 1)) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid                 = 1'b1;
                    n_out_item.expired_channel  = r_pend_ch;
                    n_out_item.expired_deferred = r_pend_mode;
                    n_out_item.last             = 1'b1;
                    n_pend_valid                = 1'b0;
                    n_state                     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_active     <= '0;
            r_mode       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_active     <= n_active;
            r_mode       <= n_mode;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_ch   <= n_pend_ch;
        r_pend_mode <= n_pend_mode;
        r_out_item  <= n_out_item;
        if (wr_en) begin
            r_remaining[wr_addr] <= wr_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/core/multi_channel_oneshot_timer_core.sv =====
// Top level of the multi-channel one-shot timer core; uses mcot_pkg,
// mcot_front, mcot_queue and mcot_back.
// A tick holds the shared decrementer while it visits each channel, plus
// dispatch and the final report; start and stop are carried out in the
// idle state without a sweep. Synchronous active-low reset clears all
// channels.
module multi_channel_oneshot_timer_core
    import mcot_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // Input channel: ticks, starts and stops.
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    // Output channel: one item per expired channel.
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // The front classifies each input item. Items that have no effect,
    // such as an unknown kind or a channel number beyond the bank, are
    // accepted and dropped right away. The input stalls only while the
    // command queue is full.
    t_q_status q_status;
    logic      push;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    logic      pop;

    mcot_front u_front (
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // A short queue lets new items keep arriving while the back end sweeps
    // the channels for a tick or waits on a stalled output.
    mcot_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    // The back end owns the counters and masks. A tick visits the channels
    // in ascending order with one shared decrementer. Each expiry is held
    // until the next one is found or the sweep ends, which is how the last
    // report of a tick gets its flag. Results leave through a register, so
    // the sweep only pauses when that register is still occupied.
    mcot_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
